// ===== rtl/core/brf_pkg.sv =====
// Package for the byte ring FIFO: transaction payload types, operation and
// status codes, controller state type, and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [8:0] QUEUE_LENGTH_RESET = 9'd256;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [7:0] fill_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_MOD,
    ST_FINISH
  } brf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
    logic step;
    logic finish;
  } brf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic mod_last;
  } brf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
// Controller state machine for the byte ring FIFO.
// Depends on brf_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire brf_stat_t stat,
  output brf_cmd_t       cmd,
  output logic           busy
);

  brf_state_t state;
  brf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        // Only stale pointers give a distance of a full ring or more.
        if (stat.in_range) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.step = 1'b1;
        if (stat.mod_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/brf_datapath.sv =====
// Datapath for the byte ring FIFO: length register, pointers, byte store,
// bit-serial modulo unit for the fill count, and the result register.
// Depends on brf_pkg for payload types, codes and interface structs.
`timescale 1ns / 1ps
`default_nettype none

module brf_datapath
  import brf_pkg::*;
#(
  parameter int MAX_DEPTH = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     queue_length_we,
  input  wire logic [8:0] queue_length,
  input  wire in_item_t item,
  input  wire brf_cmd_t cmd,
  output brf_stat_t     stat,
  output result_t       result,
  output logic          done
);

  localparam int PTR_W = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
  localparam int LEN_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (LEN_W > 9) ? LEN_W : 9;
  localparam int CNT_W = $clog2(PTR_W + 1);

  logic [8:0]       length_reg;
  logic [LEN_W-1:0] len;
  logic [CMP_W-1:0] len_raw;

  in_item_t         item_q;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_adv;
  logic [PTR_W-1:0] rd_adv;
  logic             is_full;
  logic             is_empty;

  logic [7:0]       store [MAX_DEPTH];
  logic [7:0]       rd_byte;
  logic             pop_ok;
  logic [1:0]       status_q;

  logic [PTR_W-1:0] diff;
  logic             wrapped;
  logic [PTR_W-1:0] dvd;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   trial;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] fill;

  // A pointer at or beyond the ring length wraps to zero.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] n);
    logic [PTR_W:0] inc;
    inc = {1'b0, p} + (PTR_W + 1)'(1);
    if (inc >= (PTR_W + 1)'(n)) begin
      return '0;
    end
    return inc[PTR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= QUEUE_LENGTH_RESET;
    end else if (queue_length_we) begin
      length_reg <= queue_length;
    end
  end

  always_comb begin
    len_raw = CMP_W'(length_reg);
    if (len_raw < CMP_W'(2)) begin
      len_raw = CMP_W'(2);
    end else if (len_raw > CMP_W'(MAX_DEPTH)) begin
      len_raw = CMP_W'(MAX_DEPTH);
    end
    len = len_raw[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= item;
    end
  end

  assign wr_adv   = advance(wr_ptr, len);
  assign rd_adv   = advance(rd_ptr, len);
  assign is_full  = (wr_adv == rd_ptr);
  assign is_empty = (wr_ptr == rd_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else if (cmd.exec) begin
      case (item_q.kind)
        KIND_PUSH: begin
          if (!is_full) begin
            wr_ptr <= wr_adv;
          end
        end
        KIND_POP: begin
          if (!is_empty) begin
            rd_ptr <= rd_adv;
          end
        end
        KIND_CLEAR: begin
          rd_ptr <= '0;
          wr_ptr <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && item_q.kind == KIND_PUSH && !is_full) begin
      store[wr_ptr] <= item_q.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_byte <= store[rd_ptr];
      pop_ok  <= (item_q.kind == KIND_POP) && !is_empty;
      if (item_q.kind == KIND_PUSH && is_full) begin
        status_q <= STATUS_FULL;
      end else if (item_q.kind == KIND_POP && is_empty) begin
        status_q <= STATUS_EMPTY;
      end else begin
        status_q <= STATUS_OK;
      end
    end
  end

  // Fill count is the pointer distance reduced modulo the ring length.
  assign wrapped       = (wr_ptr < rd_ptr);
  assign diff          = wrapped ? (rd_ptr - wr_ptr) : (wr_ptr - rd_ptr);
  assign stat.in_range = ((PTR_W + 1)'(diff) < (PTR_W + 1)'(len));
  assign stat.mod_last = (cnt == CNT_W'(1));
  assign trial         = {rem, dvd[PTR_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (stat.in_range) begin
        rem <= LEN_W'(diff);
      end else begin
        rem <= '0;
      end
      dvd <= diff;
      cnt <= CNT_W'(PTR_W);
    end else if (cmd.step) begin
      if (trial >= (LEN_W + 1)'(len)) begin
        rem <= LEN_W'(trial - (LEN_W + 1)'(len));
      end else begin
        rem <= trial[LEN_W-1:0];
      end
      dvd <= dvd << 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_comb begin
    if (wrapped && rem != '0) begin
      fill = len - rem;
    end else if (wrapped) begin
      fill = '0;
    end else begin
      fill = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status     <= status_q;
      result.read_data  <= pop_ok ? rd_byte : 8'd0;
      result.fill_count <= 8'(fill);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_unit.sv =====
// Top level of the byte ring FIFO: joins the controller and the datapath.
// Depends on brf_pkg, brf_ctrl and brf_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A transaction is offered on item with start; it is taken at a clock edge
// where start is high and busy is low. item.kind selects push, pop or clear;
// kind 3 changes nothing and reports the current fill.
// Each transaction yields one result on result, marked by done for exactly
// one cycle; the receiver has no way to stall it and must take it then.
// After acceptance the controller steps through EXEC, LOAD and FINISH; done
// rises and busy is low again in the same cycle. When the pointers are stale
// after a length change without a clear, the fill count goes through the
// bit-serial modulo unit in the MOD state, between LOAD and FINISH.
// queue_length is written when queue_length_we is high; the user must write
// it only while idle, which the block does not enforce. Values are saturated
// to the range 2 to MAX_DEPTH. Issue a clear after changing the length.
// Reset (rst, synchronous) zeroes both pointers and sets the length to 256;
// the byte store itself is not cleared.

module byte_ring_fifo_unit
  import brf_pkg::*;
#(
  parameter int MAX_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   item,
  output logic            done,
  output result_t         result,
  input  wire logic       queue_length_we,
  input  wire logic [8:0] queue_length
);

  brf_cmd_t  cmd;
  brf_stat_t stat;

  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  brf_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .queue_length_we (queue_length_we),
    .queue_length    (queue_length),
    .item            (item),
    .cmd             (cmd),
    .stat            (stat),
    .result          (result),
    .done            (done)
  );

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.finish))
    else $error("result strobe without a finishing transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("controller did not go busy after accepting a transaction");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_OK || result.status == STATUS_FULL ||
              result.status == STATUS_EMPTY))
    else $error("illegal status code on a result");

  a_refused_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_OK) |-> (result.read_data == 8'd0))
    else $error("refused transaction returned nonzero data");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for byte_ring_fifo_unit: push, pop and clear transactions at several ring
// lengths, with each result predicted by a local ring model and checked on done.
// Depends on brf_pkg and the byte_ring_fifo_unit RTL.

module tb;
  import brf_pkg::*;

  localparam int RING_MAX = 256;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] KIND_NOP = 2'd3;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  in_item_t   item;
  logic       done;
  result_t    result;
  logic       queue_length_we;
  logic [8:0] queue_length;

  // Local copy of the ring: storage, pointers and the programmed length.
  logic [7:0] ring_mem [RING_MAX];
  bit         ring_written [RING_MAX];
  int         head_idx = 0;
  int         tail_idx = 0;
  logic [8:0] ring_len_reg = QUEUE_LENGTH_RESET;

  result_t    pending_results[$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  bit         idle_enable;

  byte_ring_fifo_unit #(
    .MAX_DEPTH(RING_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .queue_length_we(queue_length_we),
    .queue_length(queue_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int active_len();
    if (ring_len_reg < 9'd2) return 2;
    if (ring_len_reg > RING_MAX) return RING_MAX;
    return int'(ring_len_reg);
  endfunction

  function automatic int wrap_next(int p, int len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  // Applies one operation to the ring copy and returns the result it should give.
  function automatic result_t fifo_apply(logic [1:0] k, logic [7:0] d);
    int len;
    int nxt;
    int diff;
    result_t r;
    len = active_len();
    r = '0;
    case (k)
      KIND_PUSH: begin
        nxt = wrap_next(tail_idx, len);
        if (nxt == head_idx) begin
          r.status = STATUS_FULL;
        end else begin
          ring_mem[tail_idx] = d;
          ring_written[tail_idx] = 1'b1;
          tail_idx = nxt;
        end
      end
      KIND_POP: begin
        if (tail_idx == head_idx) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.read_data = ring_mem[head_idx];
          head_idx = wrap_next(head_idx, len);
        end
      end
      KIND_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
      end
      default: ;
    endcase
    // With stale pointers the difference is taken modulo the length in use.
    if (tail_idx >= head_idx) diff = tail_idx - head_idx;
    else diff = len - ((head_idx - tail_idx) % len);
    r.fill_count = 8'(diff % len);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: expected none, actual %h",
                 $time, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 8'(want.status), 8'(result.status));
        check_field("read_data", want.read_data, result.read_data);
        check_field("fill_count", want.fill_count, result.fill_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_op(input logic [1:0] k, input logic [7:0] d);
    if (idle_enable && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    item <= '{kind: k, write_data: d};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(fifo_apply(k, d));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_length(input logic [8:0] v);
    wait_drained();
    queue_length_we <= 1'b1;
    queue_length <= v;
    @(posedge clk);
    queue_length_we <= 1'b0;
    ring_len_reg = v;
  endtask

  task automatic run_random(input int count, input int push_pct, input int pop_pct,
                            input int clear_pct);
    int roll;
    logic [1:0] k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < push_pct) k = KIND_PUSH;
      else if (roll < push_pct + pop_pct) k = KIND_POP;
      else if (roll < push_pct + pop_pct + clear_pct) k = KIND_CLEAR;
      else k = KIND_NOP;
      // Stale pointers may aim at a byte that was never stored; push instead.
      if (k == KIND_POP && head_idx != tail_idx && !ring_written[head_idx]) k = KIND_PUSH;
      send_op(k, 8'($urandom));
    end
  endtask

  task automatic test_basic_ops();
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'h00);
    send_op(KIND_PUSH, 8'hFF);
    send_op(KIND_NOP, 8'hFF);
    send_op(KIND_POP, 8'hFF);
    send_op(KIND_PUSH, 8'hA5);
    send_op(KIND_CLEAR, 8'h5A);
    send_op(KIND_POP, 8'h00);
  endtask

  task automatic test_length_limits();
    write_length(9'd2);
    send_op(KIND_CLEAR, 8'h00);
    send_op(KIND_PUSH, 8'h5A);
    send_op(KIND_PUSH, 8'h11);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_POP, 8'h00);
    write_length(9'd0);
    send_op(KIND_CLEAR, 8'h00);
  endtask

  task automatic test_stale_pointers();
    write_length(9'd256);
    send_op(KIND_CLEAR, 8'h00);
    for (int n = 0; n < 4; n++) send_op(KIND_PUSH, 8'(8'h31 + n));
    // Shrink the ring under live pointers, with no clear afterwards.
    write_length(9'd3);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'hC3);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'h3C);
    write_length(9'd256);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_CLEAR, 8'h00);
  endtask

  task automatic test_fill_and_drain();
    write_length(9'd256);
    send_op(KIND_CLEAR, 8'h00);
    idle_enable = 1'b0;
    run_random(300, 97, 2, 0);
    idle_enable = 1'b1;
    run_random(100, 8, 90, 0);
  endtask

  task automatic test_random_lengths();
    logic [8:0] lengths [7] = '{9'd2, 9'd3, 9'd1, 9'd511, 9'd17, 9'd257, 9'd100};
    foreach (lengths[i]) begin
      write_length(lengths[i]);
      send_op(KIND_CLEAR, 8'($urandom));
      run_random(35, 45, 45, 4);
    end
  endtask

  task automatic test_random_stale();
    write_length(9'd200);
    send_op(KIND_CLEAR, 8'h00);
    run_random(30, 70, 25, 0);
    write_length(9'd5);
    run_random(30, 45, 45, 0);
    write_length(9'd256);
    run_random(20, 45, 45, 0);
    send_op(KIND_CLEAR, 8'h00);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    queue_length_we = 1'b0;
    queue_length = QUEUE_LENGTH_RESET;
    idle_enable = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_length_limits();
    test_stale_pointers();
    test_fill_and_drain();
    test_random_lengths();
    test_random_stale();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== byte_ring_fifo_unit.f =====
rtl/core/brf_pkg.sv
rtl/core/brf_ctrl.sv
rtl/core/brf_datapath.sv
rtl/core/byte_ring_fifo_unit.sv
test/tb.sv
